>>> src/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// bcmc_pkg: shared types and helpers for the chunk match counter
// Tag and command codes, the operation word passed from front to back end,
// and the chunk start/end rules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcmc_pkg;

  localparam int TypeBits  = 8;
  localparam int CountBits = 32;
  localparam int OutBits   = 32;
  localparam int QDepth    = 2;
  localparam int QPtrBits  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntBits  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    TAG_O   = 2'd0,
    TAG_B   = 2'd1,
    TAG_I   = 2'd2,
    TAG_DOT = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    CMD_TOKEN    = 2'd0,
    CMD_SENT_END = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_NP_ONLY = 1'b0,
    REG_NP_TYPE = 1'b1
  } reg_idx_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic                np_only;
    logic [TypeBits-1:0] np_type;
  } cfg_t;

  // Work for the counter back end, one per item
  typedef struct packed {
    logic clear;
    logic inc_match;
    logic inc_gold;
    logic inc_guess;
  } op_t;

  function automatic logic type_sel(input cfg_t cfg, input logic [TypeBits-1:0] ty);
    return !cfg.np_only || (ty == cfg.np_type);
  endfunction

  function automatic logic chunk_starts(input logic [1:0] ptag, input logic [1:0] tag,
                                        input logic [TypeBits-1:0] ptype,
                                        input logic [TypeBits-1:0] ty);
    logic s;
    if (ptag inside {TAG_B, TAG_I}) s = (tag == TAG_B);
    else s = (tag inside {TAG_B, TAG_I});
    if (!(tag inside {TAG_O, TAG_DOT}) && (ptype != ty)) s = 1'b1;
    return s;
  endfunction

  function automatic logic chunk_ends(input logic [1:0] ptag, input logic [1:0] tag,
                                      input logic [TypeBits-1:0] ptype,
                                      input logic [TypeBits-1:0] ty);
    logic e;
    e = 1'b0;
    if (ptag inside {TAG_B, TAG_I}) e = (tag inside {TAG_B, TAG_O});
    if (!(ptag inside {TAG_O, TAG_DOT}) && (ptype != ty)) e = 1'b1;
    return e;
  endfunction

endpackage

`default_nettype wire

>>> src/bcmc_front.sv
// ----------------------------------------------------------------------------
// bcmc_front: tag history and chunk classification
// Accepts items, tracks previous tags and the open-match flag, and emits one
// counter operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

module bcmc_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire bcmc_pkg::cfg_t            cfg_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [1:0]                      command_i,
  input  wire [1:0]                      gold_tag_i,
  input  wire [bcmc_pkg::TypeBits-1:0]   gold_type_i,
  input  wire [1:0]                      guess_tag_i,
  input  wire [bcmc_pkg::TypeBits-1:0]   guess_type_i,
  output logic                           push_o,
  output bcmc_pkg::op_t                  op_o,
  input  wire                            full_i
);
  import bcmc_pkg::*;

  logic [1:0]          pgt_q, ppt_q;
  logic [TypeBits-1:0] pgty_q, ppty_q;
  logic                in_match_q;

  logic                is_tok, is_se, take;
  logic [1:0]          gt, pt;
  logic [TypeBits-1:0] gty, pty;
  logic                ge, pe, gs, ps, close, in_mid, in_after, m1, m2;

  // Pick the token this item applies: a sentence end is an O/O token
  always_comb begin
    is_tok = (command_i == CMD_TOKEN);
    is_se  = (command_i == CMD_SENT_END);
    take   = is_tok || is_se;
    gt     = is_se ? TAG_O : gold_tag_i;
    pt     = is_se ? TAG_O : guess_tag_i;
    gty    = is_se ? '0 : gold_type_i;
    pty    = is_se ? '0 : guess_type_i;
  end

  // Classify chunk boundaries against the held history
  always_comb begin
    ge       = chunk_ends(pgt_q, gt, pgty_q, gty);
    pe       = chunk_ends(ppt_q, pt, ppty_q, pty);
    gs       = chunk_starts(pgt_q, gt, pgty_q, gty);
    ps       = chunk_starts(ppt_q, pt, ppty_q, pty);
    close    = in_match_q && ge && pe && (ppty_q == pgty_q);
    m1       = close && type_sel(cfg_i, pgty_q);
    in_mid   = in_match_q && !close && (ge == pe) && (pty == gty);
    in_after = in_mid || (gs && ps && (pty == gty));
    m2       = is_se && in_after && type_sel(cfg_i, '0);
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    op_o.clear     = (command_i == CMD_CLEAR);
    op_o.inc_match = take && (m1 || m2);
    op_o.inc_gold  = take && gs && type_sel(cfg_i, gty);
    op_o.inc_guess = take && ps && type_sel(cfg_i, pty);
  end

  // Advance the history on each accepted token, drop it at sentence end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgt_q      <= TAG_O;
      ppt_q      <= TAG_O;
      pgty_q     <= '0;
      ppty_q     <= '0;
      in_match_q <= 1'b0;
    end else if (push_o && take) begin
      if (is_se) begin
        pgt_q      <= TAG_O;
        ppt_q      <= TAG_O;
        pgty_q     <= '0;
        ppty_q     <= '0;
        in_match_q <= 1'b0;
      end else begin
        pgt_q      <= gt;
        ppt_q      <= pt;
        pgty_q     <= gty;
        ppty_q     <= pty;
        in_match_q <= in_after;
      end
    end
  end

  // An open match always sits on equal types in both streams
  a_match_open_same_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_match_q |-> (pgty_q == ppty_q))
    else $error("open match with differing types");
  a_se_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && is_se) |=> !in_match_q && (pgt_q == TAG_O) && (pgty_q == '0))
    else $error("sentence end left history");
  a_clear_no_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o.clear |-> !op_o.inc_match && !op_o.inc_gold && !op_o.inc_guess)
    else $error("clear carries increments");

endmodule

`default_nettype wire

>>> src/bcmc_queue.sv
// ----------------------------------------------------------------------------
// bcmc_queue: short operation queue between front and back end
// Lets the front keep accepting while the back end waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module bcmc_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wire bcmc_pkg::op_t push_op_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           empty_o,
  output bcmc_pkg::op_t  pop_op_o
);
  import bcmc_pkg::*;

  op_t                 mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QCntBits-1:0] cnt_q;

  assign full_o   = (cnt_q == QCntBits'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign pop_op_o = mem_q[rd_q];

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_op_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QPtrBits'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntBits'(QDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> src/bcmc_back.sv
// ----------------------------------------------------------------------------
// bcmc_back: saturating chunk counters and result register
// Applies one operation per cycle while the output is not stalled and
// presents the counts as the result.
`default_nettype none

module bcmc_back (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           empty_i,
  input  wire bcmc_pkg::op_t            op_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [bcmc_pkg::OutBits-1:0]  matched_chunks_o,
  output logic [bcmc_pkg::OutBits-1:0]  gold_chunks_o,
  output logic [bcmc_pkg::OutBits-1:0]  guessed_chunks_o
);
  import bcmc_pkg::*;

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [CountBits-1:0] match_q, match_d, gold_q, gold_d, guess_q, guess_d;
  logic                 valid_q;

  // Take the next operation once the result register is free
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    match_d = match_q;
    gold_d  = gold_q;
    guess_d = guess_q;
    if (op_i.clear) begin
      match_d = '0;
      gold_d  = '0;
      guess_d = '0;
    end else begin
      if (op_i.inc_match && match_q != CountMax) match_d = match_q + 1'b1;
      if (op_i.inc_gold  && gold_q  != CountMax) gold_d  = gold_q + 1'b1;
      if (op_i.inc_guess && guess_q != CountMax) guess_d = guess_q + 1'b1;
    end
  end

  // Update counters and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      gold_q  <= '0;
      guess_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        match_q <= match_d;
        gold_q  <= gold_d;
        guess_q <= guess_d;
      end
      if (pop_o) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = valid_q;
  assign matched_chunks_o = OutBits'(match_q);
  assign gold_chunks_o    = OutBits'(gold_q);
  assign guessed_chunks_o = OutBits'(guess_q);

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && op_i.clear) |=> (match_q == '0) && (gold_q == '0) && (guess_q == '0))
    else $error("clear did not zero counters");
  a_gold_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !op_i.clear && op_i.inc_gold) |=> (gold_q != '0))
    else $error("gold counter wrapped");
  a_match_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(match_q))
    else $error("counter moved without an operation");

endmodule

`default_nettype wire

>>> src/bio_chunk_match_counter.sv
// ----------------------------------------------------------------------------
// bio_chunk_match_counter: CoNLL-style chunk match counter
// Counts gold, predicted and exactly matched chunks from BIO tag pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command per item:
//   a token pair, a sentence end, a counter clear or a no-op. Output channel
//   (out_valid_o / out_stall_i) returns one result per item: the three
//   running counts after that item, saturating at all ones.
//   Configuration (cfg_valid_i / cfg_ready_o) writes np_only_mode at index 0
//   and np_type_id at index 1; cfg_ready_o is always high. Write only while
//   no item is in flight.
//   Throughput: one item per cycle while out_stall_i is low. The front end
//   classifies the item in the cycle it is accepted; its operation is
//   written into the two-entry queue and then moves into the counter
//   register, which drives the result.
//   When the receiver stalls, the result holds, the counter stage stops and
//   the queue fills; in_stall_o rises once both queue entries are taken.
//   Reset clears history, counters and the queue, and sets np_only_mode to 0
//   and np_type_id to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module bio_chunk_match_counter (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire                           cfg_index_i,
  input  wire [bcmc_pkg::TypeBits-1:0]  cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [1:0]                     command_i,
  input  wire [1:0]                     gold_tag_i,
  input  wire [bcmc_pkg::TypeBits-1:0]  gold_type_i,
  input  wire [1:0]                     guess_tag_i,
  input  wire [bcmc_pkg::TypeBits-1:0]  guess_type_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [bcmc_pkg::OutBits-1:0]  matched_chunks_o,
  output logic [bcmc_pkg::OutBits-1:0]  gold_chunks_o,
  output logic [bcmc_pkg::OutBits-1:0]  guessed_chunks_o
);
  import bcmc_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  op_t  push_op, pop_op;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.np_only <= 1'b0;
      cfg_q.np_type <= TypeBits'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NP_ONLY: cfg_q.np_only <= cfg_wdata_i[0];
        REG_NP_TYPE: cfg_q.np_type <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bcmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .gold_tag_i   (gold_tag_i),
    .gold_type_i  (gold_type_i),
    .guess_tag_i  (guess_tag_i),
    .guess_type_i (guess_type_i),
    .push_o       (push),
    .op_o         (push_op),
    .full_i       (full)
  );

  bcmc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .pop_op_o  (pop_op)
  );

  bcmc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .op_i             (pop_op),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_chunks_o (matched_chunks_o),
    .gold_chunks_o    (gold_chunks_o),
    .guessed_chunks_o (guessed_chunks_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_bio_chunk_match_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bio_chunk_match_counter: self-checking bench for the chunk match counter
// Drives gold/predicted tag pairs, sentence ends, clears and idle commands
// with random gaps and output stalls, runs a directed table and then
// sentence-shaped random traffic under several type filter settings, and
// checks every result against a built-in chunk counting model.
// ----------------------------------------------------------------------------

module tb_bio_chunk_match_counter;
  import bcmc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumRows    = 25;
  localparam int NumPhases  = 6;

  typedef struct packed {
    logic [OutBits-1:0] matched;
    logic [OutBits-1:0] gold;
    logic [OutBits-1:0] guessed;
  } counts_t;

  typedef struct {
    cmd_e                cmd;
    tag_e                gt;
    logic [TypeBits-1:0] gty;
    tag_e                pt;
    logic [TypeBits-1:0] pty;
    bit                  known;
    logic [OutBits-1:0]  m;
    logic [OutBits-1:0]  g;
    logic [OutBits-1:0]  p;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [TypeBits-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          command_i;
  logic [1:0]          gold_tag_i;
  logic [TypeBits-1:0] gold_type_i;
  logic [1:0]          guess_tag_i;
  logic [TypeBits-1:0] guess_type_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OutBits-1:0]  matched_chunks_o;
  logic [OutBits-1:0]  gold_chunks_o;
  logic [OutBits-1:0]  guessed_chunks_o;

  // Model state: filter settings, tag history and the running counts
  bit                   np_only_q;
  logic [TypeBits-1:0]  np_type_q;
  tag_e                 last_gold_tag;
  tag_e                 last_guess_tag;
  logic [TypeBits-1:0]  last_gold_type;
  logic [TypeBits-1:0]  last_guess_type;
  bit                   chunk_open;
  logic [CountBits-1:0] n_matched;
  logic [CountBits-1:0] n_gold;
  logic [CountBits-1:0] n_guess;

  counts_t pending_counts[$];

  int  fails;
  int  cycles;
  int  n_items;
  int  n_sent_ends;
  int  n_clears;
  int  n_checked;
  int  n_cfg_writes;
  bit  calm;

  // Directed items; counts are typed in only where they are obvious
  stim_row_t dir_rows [NumRows] = '{
    '{CMD_NOP,      TAG_O,   8'd0,   TAG_O,   8'd0,   1'b1, 0, 0, 0},
    '{CMD_TOKEN,    TAG_B,   8'd1,   TAG_B,   8'd1,   1'b1, 0, 1, 1},
    '{CMD_TOKEN,    TAG_I,   8'd1,   TAG_I,   8'd1,   1'b1, 0, 1, 1},
    '{CMD_SENT_END, TAG_DOT, 8'd255, TAG_DOT, 8'd255, 1'b1, 1, 1, 1},
    '{CMD_TOKEN,    TAG_B,   8'd255, TAG_B,   8'd255, 1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd255, TAG_I,   8'd254, 1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_O,   8'd0,   TAG_O,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_DOT, 8'd0,   TAG_DOT, 8'd0,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd3,   TAG_I,   8'd3,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_DOT, 8'd3,   TAG_DOT, 8'd3,   1'b0, 0, 0, 0},
    '{CMD_SENT_END, TAG_O,   8'd0,   TAG_O,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_B,   8'd2,   TAG_I,   8'd2,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd2,   TAG_B,   8'd2,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_B,   8'd2,   TAG_O,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_O,   8'd0,   TAG_B,   8'd7,   1'b0, 0, 0, 0},
    '{CMD_NOP,      TAG_B,   8'd255, TAG_I,   8'd255, 1'b0, 0, 0, 0},
    '{CMD_CLEAR,    TAG_DOT, 8'd255, TAG_DOT, 8'd255, 1'b1, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd0,   TAG_I,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd0,   TAG_B,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_SENT_END, TAG_B,   8'd170, TAG_I,   8'd85,  1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_B,   8'd128, TAG_B,   8'd128, 1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd128, TAG_I,   8'd128, 1'b0, 0, 0, 0},
    '{CMD_TOKEN,    TAG_I,   8'd1,   TAG_I,   8'd1,   1'b0, 0, 0, 0},
    '{CMD_SENT_END, TAG_O,   8'd0,   TAG_O,   8'd0,   1'b0, 0, 0, 0},
    '{CMD_CLEAR,    TAG_O,   8'd0,   TAG_O,   8'd0,   1'b1, 0, 0, 0}
  };

  bio_chunk_match_counter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .gold_tag_i      (gold_tag_i),
    .gold_type_i     (gold_type_i),
    .guess_tag_i     (guess_tag_i),
    .guess_type_i    (guess_type_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .matched_chunks_o(matched_chunks_o),
    .gold_chunks_o   (gold_chunks_o),
    .guessed_chunks_o(guessed_chunks_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Chunk counting model
  // ---------------------------------------------------------------------------

  function automatic bit opens_chunk(tag_e ptag, tag_e tag, logic [TypeBits-1:0] pty,
                                     logic [TypeBits-1:0] ty);
    bit s;
    if (ptag == TAG_B || ptag == TAG_I) s = (tag == TAG_B);
    else s = (tag == TAG_B || tag == TAG_I);
    if (tag != TAG_O && tag != TAG_DOT && pty != ty) s = 1'b1;
    return s;
  endfunction

  function automatic bit closes_chunk(tag_e ptag, tag_e tag, logic [TypeBits-1:0] pty,
                                      logic [TypeBits-1:0] ty);
    bit e;
    e = 1'b0;
    if (ptag == TAG_B || ptag == TAG_I) e = (tag == TAG_B || tag == TAG_O);
    if (ptag != TAG_O && ptag != TAG_DOT && pty != ty) e = 1'b1;
    return e;
  endfunction

  function automatic bit type_counted(logic [TypeBits-1:0] ty);
    return !np_only_q || ty == np_type_q;
  endfunction

  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advance the history by one tag pair and update the counts
  function automatic void take_pair(tag_e gt, logic [TypeBits-1:0] gty, tag_e pt,
                                    logic [TypeBits-1:0] pty);
    bit ge, pe, gs, ps;
    if (chunk_open) begin
      ge = closes_chunk(last_gold_tag, gt, last_gold_type, gty);
      pe = closes_chunk(last_guess_tag, pt, last_guess_type, pty);
      if (ge && pe && last_guess_type == last_gold_type) begin
        chunk_open = 1'b0;
        if (type_counted(last_gold_type)) n_matched = sat_inc(n_matched);
      end else if (ge != pe || pty != gty) begin
        chunk_open = 1'b0;
      end
    end
    gs = opens_chunk(last_gold_tag, gt, last_gold_type, gty);
    ps = opens_chunk(last_guess_tag, pt, last_guess_type, pty);
    if (gs && ps && pty == gty) chunk_open = 1'b1;
    if (gs && type_counted(gty)) n_gold = sat_inc(n_gold);
    if (ps && type_counted(pty)) n_guess = sat_inc(n_guess);
    last_gold_tag   = gt;
    last_gold_type  = gty;
    last_guess_tag  = pt;
    last_guess_type = pty;
  endfunction

  function automatic void forget_history();
    last_gold_tag   = TAG_O;
    last_gold_type  = '0;
    last_guess_tag  = TAG_O;
    last_guess_type = '0;
    chunk_open      = 1'b0;
  endfunction

  function automatic counts_t predict_counts(cmd_e c, tag_e gt, logic [TypeBits-1:0] gty,
                                             tag_e pt, logic [TypeBits-1:0] pty);
    counts_t r;
    case (c)
      CMD_TOKEN: begin
        take_pair(gt, gty, pt, pty);
      end
      CMD_SENT_END: begin
        // Close the sentence on an untyped O/O pair; a chunk still open counts
        take_pair(TAG_O, '0, TAG_O, '0);
        if (chunk_open && type_counted(last_gold_type)) n_matched = sat_inc(n_matched);
        forget_history();
      end
      CMD_CLEAR: begin
        n_matched = '0;
        n_gold    = '0;
        n_guess   = '0;
      end
      default: ;
    endcase
    r.matched = n_matched[OutBits-1:0];
    r.gold    = n_gold[OutBits-1:0];
    r.guessed = n_guess[OutBits-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Gap and stall lengths: mostly short, a few long, none during calm stretches
  // ---------------------------------------------------------------------------

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(40, 200)) @(posedge clk_i);
      calm <= ~calm;
    end
  end

  // Receiver: stall at random
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one item, hold it until taken, then log its expected counts.
  // Valid stays high afterwards so that the next item can follow directly.
  task automatic send_item(cmd_e c, tag_e gt, logic [TypeBits-1:0] gty, tag_e pt,
                           logic [TypeBits-1:0] pty, bit known, counts_t typed);
    int      n;
    counts_t want;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= c;
    gold_tag_i   <= gt;
    gold_type_i  <= gty;
    guess_tag_i  <= pt;
    guess_type_i <= pty;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_counts(c, gt, gty, pt, pty);
    if (known) begin
      if (want != typed) begin
        $error("table row disagrees with model for command %s", c.name());
        fails++;
      end
      want = typed;
    end
    pending_counts.push_back(want);
    n_items++;
    if (c == CMD_SENT_END) n_sent_ends++;
    if (c == CMD_CLEAR) n_clears++;
  endtask

  // Drop valid and hold off until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  // Write both filter registers back to back, in random order
  task automatic write_filter(bit only, logic [TypeBits-1:0] ty);
    reg_idx_e first_idx;
    reg_idx_e idx;
    first_idx = $urandom_range(0, 1) ? REG_NP_TYPE : REG_NP_ONLY;
    for (int k = 0; k < 2; k++) begin
      idx = (k == 0) ? first_idx : ((first_idx == REG_NP_ONLY) ? REG_NP_TYPE : REG_NP_ONLY);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= (idx == REG_NP_ONLY) ? {{(TypeBits-1){1'b0}}, only} : ty;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx == REG_NP_ONLY) np_only_q = only;
      else np_type_q = ty;
      n_cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [TypeBits-1:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return np_type_q;
    if (r < 75) return TypeBits'($urandom_range(0, 3));
    return TypeBits'($urandom_range(0, (1 << TypeBits) - 1));
  endfunction

  // Sentence-shaped traffic: chunks built from B/I runs, the guess mostly
  // copies the gold tags, with a little noise and stray clears mixed in
  task automatic run_random(int n_target);
    int                  done;
    int                  left;
    int                  r;
    tag_e                gt, pt, prev_gt;
    logic [TypeBits-1:0] gty, pty, prev_gty;
    cmd_e                c;
    counts_t             none;
    none     = '{default: '0};
    done     = 0;
    left     = $urandom_range(1, 12);
    prev_gt  = TAG_O;
    prev_gty = '0;
    while (done < n_target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        c = cmd_e'($urandom_range(0, 3));
        send_item(c, tag_e'($urandom_range(0, 3)), TypeBits'($urandom),
                  tag_e'($urandom_range(0, 3)), TypeBits'($urandom), 1'b0, none);
        if (c != CMD_NOP) done++;
        if (c == CMD_SENT_END) prev_gt = TAG_O;
      end else if (left == 0) begin
        send_item(CMD_SENT_END, tag_e'($urandom_range(0, 3)), TypeBits'($urandom),
                  tag_e'($urandom_range(0, 3)), TypeBits'($urandom), 1'b0, none);
        done++;
        left    = $urandom_range(1, 12);
        prev_gt = TAG_O;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) gt = TAG_O;
        else if (r < 55) gt = TAG_B;
        else if (r < 92) gt = TAG_I;
        else gt = TAG_DOT;
        if (gt == TAG_I && (prev_gt == TAG_B || prev_gt == TAG_I)
            && $urandom_range(0, 99) < 85) gty = prev_gty;
        else if ((gt == TAG_O || gt == TAG_DOT) && $urandom_range(0, 9) != 0) gty = '0;
        else gty = pick_type();
        r = $urandom_range(0, 99);
        pt  = gt;
        pty = gty;
        if (r >= 88) pt = tag_e'($urandom_range(0, 3));
        else if (r >= 76) pty = pick_type();
        send_item(CMD_TOKEN, gt, gty, pt, pty, 1'b0, none);
        done++;
        left--;
        prev_gt  = gt;
        prev_gty = gty;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    counts_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result: matched %0d gold %0d guessed %0d",
               matched_chunks_o, gold_chunks_o, guessed_chunks_o);
        fails++;
      end else begin
        want = pending_counts.pop_front();
        n_checked++;
        if (matched_chunks_o !== want.matched) begin
          $error("matched_chunks: expected %0d, got %0d", want.matched, matched_chunks_o);
          fails++;
        end
        if (gold_chunks_o !== want.gold) begin
          $error("gold_chunks: expected %0d, got %0d", want.gold, gold_chunks_o);
          fails++;
        end
        if (guessed_chunks_o !== want.guessed) begin
          $error("guessed_chunks: expected %0d, got %0d", want.guessed, guessed_chunks_o);
          fails++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_counts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    bit                  plan_only [NumPhases];
    logic [TypeBits-1:0] plan_type [NumPhases];
    counts_t             typed;

    fails        = 0;
    cycles       = 0;
    n_items      = 0;
    n_sent_ends  = 0;
    n_clears     = 0;
    n_checked    = 0;
    n_cfg_writes = 0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_NP_ONLY;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    command_i    = CMD_NOP;
    gold_tag_i   = TAG_O;
    gold_type_i  = '0;
    guess_tag_i  = TAG_O;
    guess_type_i = '0;

    // Model starts from the reset state
    np_only_q = 1'b0;
    np_type_q = 8'd1;
    forget_history();
    n_matched = '0;
    n_gold    = '0;
    n_guess   = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table under the reset settings
    foreach (dir_rows[i]) begin
      typed.matched = dir_rows[i].m;
      typed.gold    = dir_rows[i].g;
      typed.guessed = dir_rows[i].p;
      send_item(dir_rows[i].cmd, dir_rows[i].gt, dir_rows[i].gty, dir_rows[i].pt,
                dir_rows[i].pty, dir_rows[i].known, typed);
    end

    // Filter settings per phase: selected type at both extremes and at zero
    plan_only = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    plan_type[0] = 8'd1;
    plan_type[1] = 8'd255;
    plan_type[2] = 8'd0;
    plan_type[3] = 8'd0;
    plan_type[4] = TypeBits'($urandom_range(1, 3));
    plan_type[5] = TypeBits'($urandom_range(0, 255));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      repeat (3) @(posedge clk_i);
      write_filter(plan_only[ph], plan_type[ph]);
      if (ph == 1) begin
        // Let the pipeline run dry once in the middle of a phase
        run_random(50);
        drain();
        run_random(50);
      end else begin
        run_random(100);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("sent %0d items (%0d sentence ends, %0d clears) over %0d filter settings",
             n_items, n_sent_ends, n_clears, NumPhases + 1);
    $display("checked %0d results, %0d register writes, %0d mismatches",
             n_checked, n_cfg_writes, fails);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
